### design/damped_cholesky_step_solver_macros.svh
// Assertion macros shared by the damped Cholesky step solver.
// Needs signals named clk and arst_n in the including module.
`ifndef DAMPED_CHOLESKY_STEP_SOLVER_MACROS_SVH
`define DAMPED_CHOLESKY_STEP_SOLVER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DCS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DCS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/dcs_pkg.sv
// Package for the damped Cholesky step solver: value type, unit handshake
// structs, item and register codes and the saturation helper. No dependencies.
package dcs_pkg;

	typedef logic signed [31:0] q_t;

	typedef struct packed {
		logic start;
		logic sqrt_mode;
	} dcs_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} dcs_rsp_t;

	localparam logic [1:0] KIND_MATRIX = 2'd0;
	localparam logic [1:0] KIND_VECTOR = 2'd1;
	localparam logic [1:0] KIND_SOLVE  = 2'd2;

	localparam logic [1:0] CFG_PARAMS   = 2'd0;
	localparam logic [1:0] CFG_LOWER_EN = 2'd1;
	localparam logic [1:0] CFG_UPPER_EN = 2'd2;

	function automatic q_t sat_q(input logic signed [65:0] x, input int sat_bits);
		logic signed [65:0] vmax;
		logic signed [65:0] vmin;
		vmax = (66'sd1 <<< (sat_bits - 1)) - 66'sd1;
		vmin = -vmax - 66'sd1;
		if (x > vmax) begin
			return q_t'(vmax);
		end else if (x < vmin) begin
			return q_t'(vmin);
		end
		return q_t'(x);
	endfunction

endpackage

### design/dcs_mac.sv
// Shared multiplier of the solver: registered product, Q16.16 rounding and a
// saturating subtract from the running sum. Depends on dcs_pkg.
module dcs_mac #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic        clk,
	input  logic        en,
	input  dcs_pkg::q_t a,
	input  dcs_pkg::q_t b,
	input  dcs_pkg::q_t acc,
	output dcs_pkg::q_t diff
);
	import dcs_pkg::*;

	localparam int SAT_BITS = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;

	logic signed [63:0] prod_s1;
	logic signed [63:0] rnd;
	q_t                 prod_q;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= 64'(a) * 64'(b);
		end
	end

	assign rnd    = (prod_s1 + 64'sd32768) >>> 16;
	assign prod_q = sat_q(66'(rnd), SAT_BITS);
	assign diff   = sat_q(66'(acc) - 66'(prod_q), SAT_BITS);

endmodule

### design/dcs_divsqrt.sv
// Shared bit-serial unit of the solver: rounded Q16.16 division and rounded
// square root, one result bit per cycle. Depends on dcs_pkg.
module dcs_divsqrt #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  dcs_pkg::dcs_req_t req,
	input  dcs_pkg::q_t       a,
	input  dcs_pkg::q_t       b,
	output dcs_pkg::dcs_rsp_t rsp,
	output dcs_pkg::q_t       result
);
	import dcs_pkg::*;

	localparam int SAT_BITS = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;

	logic        busy_q;
	logic        done_q;
	logic        mode_q;
	logic        neg_q;
	logic [5:0]  cnt_q;
	logic [33:0] rem_q;
	logic [47:0] num_q;
	logic [47:0] quo_q;
	logic [31:0] den_q;
	q_t          result_q;

	logic [31:0] ua;
	logic [31:0] ub;
	logic [31:0] na;
	logic [31:0] nb;
	logic [33:0] rem_sh;
	logic [33:0] trial;
	logic        ge;
	logic [47:0] mag;
	logic signed [65:0] fin;

	assign ua = a;
	assign ub = b;
	assign na = ua[31] ? (~ua + 32'd1) : ua;
	assign nb = ub[31] ? (~ub + 32'd1) : ub;

	always_comb begin
		if (mode_q) begin
			rem_sh = {rem_q[31:0], num_q[47:46]};
			trial  = {quo_q[31:0], 2'b01};
		end else begin
			rem_sh = {rem_q[32:0], num_q[47]};
			trial  = {2'b00, den_q};
		end
		ge  = (rem_sh >= trial);
		mag = quo_q;
		if (mode_q && (48'(rem_q) > quo_q)) begin
			mag = quo_q + 48'd1;
		end
		fin = neg_q ? -66'(mag) : 66'(mag);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 6'd1;
				end
			end else if (req.start) begin
				if (!req.sqrt_mode && (ub == '0)) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					cnt_q  <= req.sqrt_mode ? 6'd24 : 6'd48;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			if (cnt_q == '0) begin
				result_q <= sat_q(fin, SAT_BITS);
			end else begin
				rem_q <= ge ? (rem_sh - trial) : rem_sh;
				quo_q <= {quo_q[46:0], ge};
				num_q <= mode_q ? {num_q[45:0], 2'b00} : {num_q[46:0], 1'b0};
			end
		end else if (req.start) begin
			mode_q <= req.sqrt_mode;
			rem_q  <= '0;
			quo_q  <= '0;
			den_q  <= nb;
			if (req.sqrt_mode) begin
				neg_q <= 1'b0;
				num_q <= {ua, 16'd0};
			end else begin
				neg_q <= ua[31] ^ ub[31];
				num_q <= {na, 16'd0} + 48'(nb >> 1);
			end
			if (!req.sqrt_mode && (ub == '0)) begin
				if (ua == '0) begin
					result_q <= '0;
				end else begin
					result_q <= sat_q(ua[31] ? -66'sd1 <<< 40 : 66'sd1 <<< 40, SAT_BITS);
				end
			end
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign result   = result_q;

endmodule

### design/damped_cholesky_step_solver.sv
// Top level of the damped Cholesky step solver: stores, sequencer and output
// register. Depends on dcs_pkg, dcs_mac, dcs_divsqrt and the assertion macros.
//
// Load items (matrix or parameter vector) are taken while the input is not
// stalled. A solve item keeps the input stalled while one multiplier and one
// bit-serial divide and root unit work through the factorisation, the two
// substitutions or the damped-gradient fallback, and the output. Each
// multiply term passes through the read, multiply and subtract states, and
// the solve time is set mainly by the shared divide and root unit.
`include "damped_cholesky_step_solver_macros.svh"

module damped_cholesky_step_solver #(
	parameter int MAX_PARAMS  = 8,
	parameter int VALUE_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [3:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [2:0]  row,
	input  logic [2:0]  col,
	input  dcs_pkg::q_t matrix_value,
	input  dcs_pkg::q_t gradient_value,
	input  dcs_pkg::q_t current_param,
	input  dcs_pkg::q_t lower_limit,
	input  dcs_pkg::q_t upper_limit,
	input  logic [30:0] damping,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  param_index,
	output dcs_pkg::q_t trial_param,
	output dcs_pkg::q_t step_value,
	output logic        factor_ok,
	output logic        last
);
	import dcs_pkg::*;

	localparam int SAT_BITS  = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
	localparam int IW        = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
	localparam int CW        = $clog2(MAX_PARAMS + 1);
	localparam int VEC_DEPTH = 1 << IW;
	localparam int MAT_DEPTH = 1 << (2 * IW);

	typedef enum logic [10:0] {
		S_IDLE  = 11'b00000000001,
		S_INIT  = 11'b00000000010,
		S_LOAD  = 11'b00000000100,
		S_RD    = 11'b00000001000,
		S_MUL   = 11'b00000010000,
		S_SUB   = 11'b00000100000,
		S_DRD   = 11'b00001000000,
		S_DIV   = 11'b00010000000,
		S_WAIT  = 11'b00100000000,
		S_ORD   = 11'b01000000000,
		S_OCALC = 11'b10000000000
	} state_t;

	typedef enum logic [4:0] {
		PH_CHOL  = 5'b00001,
		PH_FWD   = 5'b00010,
		PH_BWD   = 5'b00100,
		PH_FALLB = 5'b01000,
		PH_OUT   = 5'b10000
	} phase_t;

	state_t          state_q;
	phase_t          phase_q;
	logic [CW-1:0]   i_q;
	logic [CW-1:0]   j_q;
	logic [CW-1:0]   k_q;
	logic [CW-1:0]   n_q;
	q_t              lambda_q;
	q_t              s_q;
	logic            ok_q;
	logic [3:0]      params_q;
	logic            lo_en_q;
	logic            up_en_q;

	q_t mat_store  [MAT_DEPTH];
	q_t fact_store [MAT_DEPTH];
	q_t grad_store [VEC_DEPTH];
	q_t par_store  [VEC_DEPTH];
	q_t lo_store   [VEC_DEPTH];
	q_t up_store   [VEC_DEPTH];
	q_t sv_store   [VEC_DEPTH];

	q_t m_rd_q;
	q_t fa_rd_q;
	q_t fb_rd_q;
	q_t g_rd_q;
	q_t p_rd_q;
	q_t lo_rd_q;
	q_t up_rd_q;
	q_t sv_rd_q;

	logic            out_valid_q;
	logic [2:0]      out_index_q;
	q_t              out_trial_q;
	q_t              out_step_q;
	logic            out_ok_q;
	logic            out_last_q;

	logic [IW-1:0]   ii;
	logic [IW-1:0]   jj;
	logic [IW-1:0]   kk;
	logic [2*IW-1:0] mat_addr;
	logic [2*IW-1:0] fa_addr;
	logic [2*IW-1:0] fb_addr;
	logic [IW-1:0]   sv_addr;
	logic [CW-1:0]   kstart;
	logic [CW-1:0]   kend;
	q_t              y_op;
	q_t              mac_diff;
	q_t              init_val;
	q_t              trial_t;
	q_t              trial_lo;
	q_t              trial_clamp;
	logic            diag;
	logic            pivot_bad;
	logic            in_acc;
	logic            out_free;
	logic            row_ok;
	dcs_req_t        dv_req;
	dcs_rsp_t        dv_rsp;
	q_t              dv_b;
	q_t              dv_result;

	assign ii        = i_q[IW-1:0];
	assign jj        = j_q[IW-1:0];
	assign kk        = k_q[IW-1:0];
	assign diag      = (i_q == j_q);
	assign pivot_bad = s_q[31] || (s_q == '0);
	assign in_stall  = (state_q != S_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || !out_stall;
	assign row_ok    = (32'(row) < MAX_PARAMS);

	always_comb begin
		mat_addr = {ii, jj};
		sv_addr  = (state_q == S_RD) ? kk : ii;
		fa_addr  = (phase_q == PH_BWD) ? {kk, ii} : {ii, kk};
		if (state_q == S_DRD) begin
			fb_addr = (phase_q == PH_CHOL) ? {jj, jj} : {ii, ii};
		end else begin
			fb_addr = {jj, kk};
		end
		case (phase_q)
			PH_CHOL: begin
				kstart = '0;
				kend   = j_q;
			end
			PH_FWD: begin
				kstart = '0;
				kend   = i_q;
			end
			PH_BWD: begin
				kstart = i_q + CW'(1);
				kend   = n_q;
			end
			default: begin
				kstart = '0;
				kend   = '0;
			end
		endcase
		y_op = (phase_q == PH_CHOL) ? fb_rd_q : sv_rd_q;
		case (phase_q)
			PH_CHOL:  init_val = sat_q(66'(m_rd_q) + (diag ? 66'(lambda_q) : 66'sd0),
				SAT_BITS);
			PH_BWD:   init_val = sv_rd_q;
			default:  init_val = sat_q(-66'(g_rd_q), SAT_BITS);
		endcase
		dv_req.start     = (state_q == S_DIV) && !((phase_q == PH_CHOL) && diag && pivot_bad);
		dv_req.sqrt_mode = (phase_q == PH_CHOL) && diag;
		dv_b             = (phase_q == PH_FALLB) ? lambda_q : fb_rd_q;
		trial_t          = sat_q(66'(p_rd_q) + 66'(sv_rd_q), SAT_BITS);
		trial_lo         = (lo_en_q && (trial_t < lo_rd_q)) ? lo_rd_q : trial_t;
		trial_clamp      = (up_en_q && (trial_lo > up_rd_q)) ? up_rd_q : trial_lo;
	end

	dcs_mac #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_mac (
		.clk (clk),
		.en  (state_q == S_MUL),
		.a   (fa_rd_q),
		.b   (y_op),
		.acc (s_q),
		.diff(mac_diff)
	);

	dcs_divsqrt #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_divsqrt (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (dv_req),
		.a     (s_q),
		.b     (dv_b),
		.rsp   (dv_rsp),
		.result(dv_result)
	);

	always_ff @(posedge clk) begin
		m_rd_q  <= mat_store[mat_addr];
		fa_rd_q <= fact_store[fa_addr];
		fb_rd_q <= fact_store[fb_addr];
		g_rd_q  <= grad_store[ii];
		p_rd_q  <= par_store[ii];
		lo_rd_q <= lo_store[ii];
		up_rd_q <= up_store[ii];
		sv_rd_q <= sv_store[sv_addr];
		if (in_acc && (kind == KIND_MATRIX) && (col <= row) && row_ok) begin
			mat_store[{IW'(row), IW'(col)}] <= sat_q(66'(matrix_value), SAT_BITS);
		end
		if (in_acc && (kind == KIND_VECTOR) && row_ok) begin
			grad_store[IW'(row)] <= sat_q(66'(gradient_value), SAT_BITS);
			par_store[IW'(row)]  <= sat_q(66'(current_param), SAT_BITS);
			lo_store[IW'(row)]   <= sat_q(66'(lower_limit), SAT_BITS);
			up_store[IW'(row)]   <= sat_q(66'(upper_limit), SAT_BITS);
		end
		if ((state_q == S_WAIT) && dv_rsp.done) begin
			if (phase_q == PH_CHOL) begin
				fact_store[{ii, jj}] <= dv_result;
			end else begin
				sv_store[ii] <= dv_result;
			end
		end
		if (state_q == S_LOAD) begin
			s_q <= init_val;
		end else if (state_q == S_SUB) begin
			s_q <= mac_diff;
		end
		if (in_acc && (kind == KIND_SOLVE)) begin
			lambda_q <= sat_q(66'(damping), SAT_BITS);
		end
		if ((state_q == S_OCALC) && out_free) begin
			out_index_q <= 3'(i_q);
			out_trial_q <= trial_clamp;
			out_step_q  <= sv_rd_q;
			out_ok_q    <= ok_q;
			out_last_q  <= (i_q + CW'(1) == n_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			params_q <= 4'd8;
			lo_en_q  <= 1'b0;
			up_en_q  <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_PARAMS:   params_q <= cfg_data;
				CFG_LOWER_EN: lo_en_q  <= cfg_data[0];
				CFG_UPPER_EN: up_en_q  <= cfg_data[0];
				default:      ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			phase_q     <= PH_CHOL;
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			n_q         <= '0;
			ok_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc && (kind == KIND_SOLVE)) begin
						if (params_q == '0) begin
							n_q <= CW'(1);
						end else if (32'(params_q) > MAX_PARAMS) begin
							n_q <= CW'(MAX_PARAMS);
						end else begin
							n_q <= CW'(params_q);
						end
						phase_q <= PH_CHOL;
						i_q     <= '0;
						j_q     <= '0;
						ok_q    <= 1'b1;
						state_q <= S_INIT;
					end
				end
				S_INIT: begin
					k_q     <= kstart;
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					state_q <= S_RD;
				end
				S_RD: begin
					state_q <= (k_q == kend) ? S_DRD : S_MUL;
				end
				S_MUL: begin
					state_q <= S_SUB;
				end
				S_SUB: begin
					k_q     <= k_q + CW'(1);
					state_q <= S_RD;
				end
				S_DRD: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if ((phase_q == PH_CHOL) && diag && pivot_bad) begin
						ok_q    <= 1'b0;
						phase_q <= PH_FALLB;
						i_q     <= '0;
						state_q <= S_INIT;
					end else begin
						state_q <= S_WAIT;
					end
				end
				S_WAIT: begin
					if (dv_rsp.done) begin
						state_q <= S_INIT;
						case (phase_q)
							PH_CHOL: begin
								if (diag) begin
									j_q <= '0;
									if (i_q + CW'(1) == n_q) begin
										phase_q <= PH_FWD;
										i_q     <= '0;
									end else begin
										i_q <= i_q + CW'(1);
									end
								end else begin
									j_q <= j_q + CW'(1);
								end
							end
							PH_FWD: begin
								if (i_q + CW'(1) == n_q) begin
									phase_q <= PH_BWD;
									i_q     <= n_q - CW'(1);
								end else begin
									i_q <= i_q + CW'(1);
								end
							end
							PH_BWD: begin
								if (i_q == '0) begin
									phase_q <= PH_OUT;
									state_q <= S_ORD;
								end else begin
									i_q <= i_q - CW'(1);
								end
							end
							default: begin
								if (i_q + CW'(1) == n_q) begin
									phase_q <= PH_OUT;
									i_q     <= '0;
									state_q <= S_ORD;
								end else begin
									i_q <= i_q + CW'(1);
								end
							end
						endcase
					end
				end
				S_ORD: begin
					state_q <= S_OCALC;
				end
				S_OCALC: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						if (i_q + CW'(1) == n_q) begin
							state_q <= S_IDLE;
						end else begin
							i_q     <= i_q + CW'(1);
							state_q <= S_ORD;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign param_index = out_index_q;
	assign trial_param = out_trial_q;
	assign step_value  = out_step_q;
	assign factor_ok   = out_ok_q;
	assign last        = out_last_q;

	`DCS_ASSERT_NOW(a_unit_only_in_wait, dv_rsp.busy || dv_rsp.done, state_q == S_WAIT, "divide or root unit active outside the wait state")
	`DCS_ASSERT_NOW(a_fallback_flags_fail, phase_q == PH_FALLB, !ok_q, "fallback running while the factorisation is marked good")
	`DCS_ASSERT_NEXT(a_taken_item_clears, out_valid && !out_stall && (state_q != S_OCALC), !out_valid, "result item still shown after it was taken")
	`DCS_ASSERT_NOW(a_results_from_out_phase, state_q == S_OCALC || state_q == S_ORD, phase_q == PH_OUT, "result sequencing outside the output phase")

endmodule

### sim/tb.sv
// Self-checking testbench for damped_cholesky_step_solver: loads, solves and
// checks every trial step against a bit-exact predictor. Depends on dcs_pkg and the RTL.
module tb;
	import dcs_pkg::*;

	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam longint VMAX = 64'sd2147483647;
	localparam longint VMIN = -64'sd2147483648;
	localparam int WATCHDOG_LIMIT = 100000;
	localparam int TARGET_ITEMS = 170;

	typedef struct {
		logic [1:0]  kind;
		logic [2:0]  row;
		logic [2:0]  col;
		q_t          mv;
		q_t          gv;
		q_t          cp;
		q_t          ll;
		q_t          ul;
		logic [30:0] damp;
	} stim_t;

	typedef struct {
		logic [2:0] idx;
		q_t         trial;
		q_t         step;
		logic       ok;
		logic       last;
	} step_res_t;

	typedef struct {
		bit         is_cfg;
		logic [1:0] ci;
		logic [3:0] cd;
		stim_t      s;
		bit         has_exp;
		step_res_t  e;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [3:0]  cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  kind;
	logic [2:0]  row;
	logic [2:0]  col;
	q_t          matrix_value;
	q_t          gradient_value;
	q_t          current_param;
	q_t          lower_limit;
	q_t          upper_limit;
	logic [30:0] damping;
	logic        out_valid;
	logic        out_stall;
	logic [2:0]  param_index;
	q_t          trial_param;
	q_t          step_value;
	logic        factor_ok;
	logic        last;

	damped_cholesky_step_solver u_dut (.*);

	// Predictor state.
	longint    h_mat[64];
	longint    l_fac[64];
	longint    grad[8];
	longint    pval[8];
	longint    lo_lim[8];
	longint    hi_lim[8];
	longint    sol[8];
	int        n_cfg;
	bit        lo_en;
	bit        hi_en;
	step_res_t pending_steps[$];

	int fails;
	int idle_cycles;
	int hold_len;
	bit no_idle;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic longint clip(input longint x);
		if (x > VMAX)
			return VMAX;
		if (x < VMIN)
			return VMIN;
		return x;
	endfunction

	function automatic longint fx_mul(input longint a, input longint b);
		longint p;
		p = a * b + 64'sd32768;
		return clip(p >>> 16);
	endfunction

	function automatic longint fx_div(input longint a, input longint b);
		longint na;
		longint nb;
		longint q;
		bit neg;
		neg = (a < 0) != (b < 0);
		if (b == 0) begin
			if (a == 0)
				return 0;
			return a > 0 ? VMAX : VMIN;
		end
		na = (a < 0 ? -a : a) * 64'sd65536;
		nb = b < 0 ? -b : b;
		q = (na + nb / 2) / nb;
		if (q > VMAX + 1)
			q = VMAX + 1;
		return clip(neg ? -q : q);
	endfunction

	function automatic longint fx_sqrt(input longint x);
		longint unsigned v;
		longint unsigned r;
		longint unsigned b;
		longint unsigned rem;
		v = longint'(x) * 64'd65536;
		r = 0;
		b = 64'd1 << 62;
		rem = v;
		while (b > rem)
			b >>= 2;
		while (b != 0) begin
			if (rem >= r + b) begin
				rem -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		if (rem > r)
			r++;
		return clip(longint'(r));
	endfunction

	task automatic predict_item(input stim_t s);
		int n;
		longint lam;
		longint acc;
		longint t;
		bit ok;
		step_res_t r;
		if (s.kind == KIND_MATRIX) begin
			if (s.col <= s.row)
				h_mat[s.row * 8 + s.col] = s.mv;
			return;
		end
		if (s.kind == KIND_VECTOR) begin
			grad[s.row] = s.gv;
			pval[s.row] = s.cp;
			lo_lim[s.row] = s.ll;
			hi_lim[s.row] = s.ul;
			return;
		end
		if (s.kind != KIND_SOLVE)
			return;
		n = n_cfg < 1 ? 1 : (n_cfg > 8 ? 8 : n_cfg);
		lam = longint'(s.damp);
		ok = 1'b1;
		for (int i = 0; i < n && ok; i++) begin
			for (int j = 0; j <= i; j++) begin
				acc = h_mat[i * 8 + j];
				if (i == j)
					acc = clip(acc + lam);
				for (int k = 0; k < j; k++)
					acc = clip(acc - fx_mul(l_fac[i * 8 + k], l_fac[j * 8 + k]));
				if (i == j) begin
					if (acc <= 0) begin
						ok = 1'b0;
						break;
					end
					l_fac[i * 8 + j] = fx_sqrt(acc);
				end else begin
					l_fac[i * 8 + j] = fx_div(acc, l_fac[j * 8 + j]);
				end
			end
		end
		if (ok) begin
			for (int i = 0; i < n; i++) begin
				acc = clip(-grad[i]);
				for (int k = 0; k < i; k++)
					acc = clip(acc - fx_mul(l_fac[i * 8 + k], sol[k]));
				sol[i] = fx_div(acc, l_fac[i * 8 + i]);
			end
			for (int j = n - 1; j >= 0; j--) begin
				acc = sol[j];
				for (int k = j + 1; k < n; k++)
					acc = clip(acc - fx_mul(l_fac[k * 8 + j], sol[k]));
				sol[j] = fx_div(acc, l_fac[j * 8 + j]);
			end
		end else begin
			for (int i = 0; i < n; i++)
				sol[i] = fx_div(clip(-grad[i]), lam);
		end
		for (int i = 0; i < n; i++) begin
			t = clip(pval[i] + sol[i]);
			if (lo_en && t < lo_lim[i])
				t = lo_lim[i];
			if (hi_en && t > hi_lim[i])
				t = hi_lim[i];
			r.idx = i[2:0];
			r.trial = q_t'(t);
			r.step = q_t'(sol[i]);
			r.ok = ok;
			r.last = (i == n - 1);
			pending_steps.push_back(r);
		end
	endtask

	function automatic int draw_gap();
		return no_idle ? 0 : $urandom_range(0, 16);
	endfunction

	task automatic offer(input stim_t s);
		int g;
		g = draw_gap();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= s.kind;
		row <= s.row;
		col <= s.col;
		matrix_value <= s.mv;
		gradient_value <= s.gv;
		current_param <= s.cp;
		lower_limit <= s.ll;
		upper_limit <= s.ul;
		damping <= s.damp;
		do @(posedge clk); while (in_stall);
		predict_item(s);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_steps.size() != 0);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [3:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_PARAMS: n_cfg = int'(data);
			CFG_LOWER_EN: lo_en = data[0];
			CFG_UPPER_EN: hi_en = data[0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	function automatic stim_t blank();
		stim_t s;
		s.kind = KIND_UNUSED;
		s.row = 3'($urandom);
		s.col = 3'($urandom);
		s.mv = $urandom;
		s.gv = $urandom;
		s.cp = $urandom;
		s.ll = $urandom;
		s.ul = $urandom;
		s.damp = 31'($urandom);
		return s;
	endfunction

	function automatic row_t r_cfg(input logic [1:0] ci, input logic [3:0] cd);
		row_t r;
		r.is_cfg = 1'b1;
		r.ci = ci;
		r.cd = cd;
		r.s = blank();
		r.has_exp = 1'b0;
		return r;
	endfunction

	function automatic row_t r_mat(input int i, input int j, input q_t v);
		row_t r;
		r.is_cfg = 1'b0;
		r.s = blank();
		r.s.kind = KIND_MATRIX;
		r.s.row = 3'(i);
		r.s.col = 3'(j);
		r.s.mv = v;
		r.has_exp = 1'b0;
		return r;
	endfunction

	function automatic row_t r_vec(input int i, input q_t g, input q_t p, input q_t lo,
			input q_t hi);
		row_t r;
		r.is_cfg = 1'b0;
		r.s = blank();
		r.s.kind = KIND_VECTOR;
		r.s.row = 3'(i);
		r.s.gv = g;
		r.s.cp = p;
		r.s.ll = lo;
		r.s.ul = hi;
		r.has_exp = 1'b0;
		return r;
	endfunction

	function automatic row_t r_solve(input logic [30:0] d);
		row_t r;
		r.is_cfg = 1'b0;
		r.s = blank();
		r.s.kind = KIND_SOLVE;
		r.s.damp = d;
		r.has_exp = 1'b0;
		return r;
	endfunction

	function automatic row_t with_exp(input row_t r, input q_t trial, input q_t step,
			input logic ok);
		r.has_exp = 1'b1;
		r.e.idx = 3'd0;
		r.e.trial = trial;
		r.e.step = step;
		r.e.ok = ok;
		r.e.last = 1'b1;
		return r;
	endfunction

	function automatic q_t small_q(input int span);
		return q_t'($signed($urandom_range(0, 2 * span)) - span);
	endfunction

	// Sender.
	initial begin
		row_t tab[$];
		stim_t loads[$];
		stim_t s;
		int sent;
		int phase;
		int n_eff;
		int cv;
		bit wild;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_PARAMS;
		cfg_data = 4'd0;
		in_valid = 1'b0;
		kind = KIND_MATRIX;
		row = 3'd0;
		col = 3'd0;
		matrix_value = '0;
		gradient_value = '0;
		current_param = '0;
		lower_limit = '0;
		upper_limit = '0;
		damping = '0;
		fails = 0;
		hold_len = 0;
		no_idle = 1'b0;
		n_cfg = 8;
		lo_en = 1'b0;
		hi_en = 1'b0;
		for (int i = 0; i < 64; i++) begin
			h_mat[i] = 0;
			l_fac[i] = 0;
		end
		for (int i = 0; i < 8; i++) begin
			grad[i] = 0;
			pval[i] = 0;
			lo_lim[i] = 0;
			hi_lim[i] = 0;
			sol[i] = 0;
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tab = '{
			r_cfg(CFG_PARAMS, 4'd1),
			r_mat(0, 0, 32'h8000_0000),
			r_vec(0, 32'h0001_0000, 32'h0, 32'h8000_0000, 32'h7fff_ffff),
			with_exp(r_solve(31'd0), 32'h8000_0000, 32'h8000_0000, 1'b0),
			r_mat(0, 0, 32'h7fff_ffff),
			r_solve(31'h7fff_ffff),
			s_noise_row(),
			r_mat(0, 5, 32'h1234_5678),
			r_vec(0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h0, 32'h0),
			r_solve(31'd1),
			r_cfg(CFG_PARAMS, 4'd2),
			r_cfg(CFG_LOWER_EN, 4'd1),
			r_cfg(CFG_UPPER_EN, 4'd1),
			r_mat(0, 0, 32'h0004_0000),
			r_mat(1, 0, 32'h0001_0000),
			r_mat(1, 1, 32'h0002_0000),
			r_vec(0, 32'hffff_0000, 32'h0, 32'h0010_0000, 32'h0001_0000),
			r_vec(1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff),
			r_solve(31'h0001_0000),
			r_mat(1, 1, 32'hfff8_0000),
			r_solve(31'h0001_0000),
			r_mat(7, 7, 32'h0),
			r_vec(7, 32'h0, 32'h0, 32'h0, 32'h0)
		};
		sent = 0;
		foreach (tab[i]) begin
			if (tab[i].is_cfg) begin
				wait_drained();
				write_reg(tab[i].ci, tab[i].cd);
			end else begin
				offer(tab[i].s);
				sent++;
				if (tab[i].has_exp)
					pending_steps[pending_steps.size() - 1] = tab[i].e;
			end
		end

		phase = 0;
		while (sent < TARGET_ITEMS) begin
			wait_drained();
			no_idle = (phase % 5 == 3);
			cv = $urandom_range(0, 99);
			if (cv < 8)
				cv = 0;
			else if (cv < 20)
				cv = $urandom_range(8, 15);
			else
				cv = $urandom_range(1, 4);
			write_reg(CFG_PARAMS, 4'(cv));
			write_reg(CFG_LOWER_EN, 4'($urandom_range(0, 1)));
			write_reg(CFG_UPPER_EN, 4'($urandom_range(0, 1)));
			n_eff = n_cfg < 1 ? 1 : (n_cfg > 8 ? 8 : n_cfg);
			wild = ($urandom_range(0, 99) < 25);
			loads.delete();
			for (int i = 0; i < n_eff; i++) begin
				for (int j = 0; j <= i; j++) begin
					s = blank();
					s.kind = KIND_MATRIX;
					s.row = 3'(i);
					s.col = 3'(j);
					if (!wild)
						s.mv = (i == j) ? q_t'($urandom_range(1, 8) << 16) + small_q(32768)
							: small_q(65536);
					loads.push_back(s);
				end
				s = blank();
				s.kind = KIND_VECTOR;
				s.row = 3'(i);
				if (!wild) begin
					s.gv = small_q(4 << 16);
					s.cp = small_q(16 << 16);
					s.ll = s.cp - q_t'($urandom_range(0, 2 << 16));
					s.ul = s.cp + q_t'($urandom_range(0, 2 << 16));
					if ($urandom_range(0, 9) == 0)
						s.ul = s.ll - 1;
				end
				loads.push_back(s);
			end
			loads.shuffle();
			foreach (loads[k]) begin
				if ($urandom_range(0, 9) == 0) begin
					s = blank();
					if ($urandom_range(0, 1)) begin
						s.kind = KIND_MATRIX;
						s.row = 3'($urandom_range(0, 6));
						s.col = 3'($urandom_range(int'(s.row) + 1, 7));
					end
					offer(s);
					sent++;
				end
				offer(loads[k]);
				sent++;
			end
			if (phase == 2) begin
				wait_drained();
				hold_len = 3000;
			end
			repeat ($urandom_range(1, 2)) begin
				s = blank();
				s.kind = KIND_SOLVE;
				if ($urandom_range(0, 19) == 0)
					s.damp = 31'd0;
				else if (!wild)
					s.damp = 31'($urandom_range(1, 2 << 16));
				offer(s);
				sent++;
				if (phase == 2) begin
					s.damp = 31'($urandom_range(1, 2 << 16));
					offer(s);
					sent++;
				end
			end
			phase++;
		end
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_steps.size() != 0);
		repeat (50) @(posedge clk);
		if (fails == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

	function automatic row_t s_noise_row();
		row_t r;
		r.is_cfg = 1'b0;
		r.s = blank();
		r.has_exp = 1'b0;
		return r;
	endfunction

	// Receiver.
	initial begin
		int g;
		step_res_t e;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			g = hold_len > 0 ? hold_len : draw_gap();
			hold_len = 0;
			if (g > 0) begin
				out_stall <= 1'b1;
				repeat (g) @(posedge clk);
				out_stall <= 1'b0;
			end
			do @(posedge clk); while (!out_valid && hold_len == 0);
			if (!out_valid)
				continue;
			if (pending_steps.size() == 0) begin
				$error("unexpected item: param_index %0d", param_index);
				fails++;
				continue;
			end
			e = pending_steps.pop_front();
			if (param_index !== e.idx) begin
				$error("param_index: expected %0d, actual %0d", e.idx, param_index);
				fails++;
			end
			if (trial_param !== e.trial) begin
				$error("trial_param: expected %h, actual %h", e.trial, trial_param);
				fails++;
			end
			if (step_value !== e.step) begin
				$error("step_value: expected %h, actual %h", e.step, step_value);
				fails++;
			end
			if (factor_ok !== e.ok) begin
				$error("factor_ok: expected %b, actual %b", e.ok, factor_ok);
				fails++;
			end
			if (last !== e.last) begin
				$error("last: expected %b, actual %b", e.last, last);
				fails++;
			end
		end
	end

	// A stretch with no accepted item on any channel ends the run.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("tb NOT OK");
			$finish;
		end
	end

	initial idle_cycles = 0;

endmodule

### sim.f
+incdir+design
design/dcs_pkg.sv
design/dcs_mac.sv
design/dcs_divsqrt.sv
design/damped_cholesky_step_solver.sv
sim/tb.sv
